>>> rtl/core/spwa_pkg.sv
// ----------------------------------------------------------------------------
// spwa_pkg
// Shared types and constants for the sweep peak/width averager.
// ----------------------------------------------------------------------------
package spwa_pkg;

  // sample and smoothing window
  localparam int SAMPLE_BITS = 10;
  localparam int WIN_DEPTH   = 64;
  localparam int WIN_AW      = $clog2(WIN_DEPTH);
  localparam int WSUM_W      = SAMPLE_BITS + WIN_AW;
  localparam int EXP_W       = 3;
  localparam int EXP_MIN     = 1;
  localparam int EXP_MAX     = 6;

  // per-sweep tracking
  localparam int POS_W     = 12;
  localparam int CNT_W     = 13;
  localparam int CNT_MAX   = 4096;
  localparam logic [SAMPLE_BITS-1:0] THR_INIT = SAMPLE_BITS'(16'h01ff);

  // period ring
  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int NCNT_W     = $clog2(RING_DEPTH + 1);
  localparam int PER_W      = 8;
  localparam logic [PER_W-1:0] PER_RESET = PER_W'(128);
  localparam int PK_SUM_W   = 17;
  localparam int WD_SUM_W   = 20;
  localparam int IX_SUM_W   = 19;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_EXP   = 2'd0,
    REG_PERIOD_COUNT = 2'd1
  } cfg_reg_t;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // one finished sweep
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
  } sweep_rec_t;

  // back-end status
  typedef struct packed {
    logic pop;
    logic recalc;
  } back_stat_t;

endpackage

>>> rtl/core/spwa_in_if.sv
// ----------------------------------------------------------------------------
// spwa_in_if
// Sample channel: one ADC sample per item with sweep markers.
// ----------------------------------------------------------------------------
interface spwa_in_if import spwa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   first_of_sweep;
  logic                   last_of_sweep;

  modport source (output valid, sample, first_of_sweep, last_of_sweep, input ready);
  modport sink   (input valid, sample, first_of_sweep, last_of_sweep, output ready);
endinterface

>>> rtl/core/spwa_out_if.sv
// ----------------------------------------------------------------------------
// spwa_out_if
// Result channel: per-sweep values and ring sums.
// ----------------------------------------------------------------------------
interface spwa_out_if import spwa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] peak_value;
  logic [POS_W-1:0]       peak_index;
  logic [CNT_W-1:0]       width_count;
  logic [PK_SUM_W-1:0]    peak_sum;
  logic [WD_SUM_W-1:0]    width_sum;
  logic [IX_SUM_W-1:0]    index_sum;

  modport source (output valid, peak_value, peak_index, width_count, peak_sum, width_sum,
                  index_sum, input ready);
  modport sink   (input valid, peak_value, peak_index, width_count, peak_sum, width_sum,
                  index_sum, output ready);
endinterface

>>> rtl/core/spwa_cfg_if.sv
// ----------------------------------------------------------------------------
// spwa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spwa_cfg_if import spwa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/spwa_front.sv
// ----------------------------------------------------------------------------
// spwa_front
// Sample intake: boxcar window, smoothed value, peak and width tracking.
// Pushes one sweep record per sweep end into the queue.
// ----------------------------------------------------------------------------
module spwa_front import spwa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [EXP_W-1:0] shift,
  spwa_in_if.sink         samples,
  input  logic            q_full,
  output logic            q_push,
  output sweep_rec_t      q_rec
);

  logic en, fire;
  logic [WIN_AW-1:0] win_pos, win_pos_next, wr_pos, wrap_pos;
  logic [WIN_DEPTH-1:0] win_vld;
  logic [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
  logic [SAMPLE_BITS-1:0] old_raw;

  logic                   s1_valid, s1_first, s1_last, s1_old_vld;
  logic [SAMPLE_BITS-1:0] s1_sample;

  logic [WSUM_W-1:0]      win_sum, wsum_base, wsum_next, mean_full;
  logic [SAMPLE_BITS-1:0] old_val, mean;
  logic                   s2_valid, s2_first, s2_last;
  logic [SAMPLE_BITS-1:0] s2_mean;

  logic [POS_W-1:0]       sweep_pos, peak_pos, sp_base, pp_base, sp_new, pp_new;
  logic [SAMPLE_BITS-1:0] peak, thr, pk_base, pk_new;
  logic [CNT_W-1:0]       above, cnt_base, cnt_new;

  // whole front moves together, held while the queue is full
  assign en            = !q_full;
  assign samples.ready = en;
  assign fire          = samples.valid && en;

  // window write position; a new sweep starts at slot zero
  always_comb begin
    if (int'(shift) >= WIN_AW) begin
      wrap_pos = WIN_AW'(WIN_DEPTH - 1);
    end else begin
      wrap_pos = WIN_AW'((1 << shift) - 1);
    end
    wr_pos       = samples.first_of_sweep ? '0 : win_pos;
    win_pos_next = (wr_pos == '0) ? wrap_pos : wr_pos - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_pos <= '0;
      win_vld <= '0;
    end else if (fire) begin
      win_pos <= win_pos_next;
      if (samples.first_of_sweep) begin
        win_vld <= WIN_DEPTH'(1);
      end else begin
        win_vld[wr_pos] <= 1'b1;
      end
    end
  end

  // window memory, read-first at the slot being replaced
  always_ff @(posedge clk) begin
    if (fire) begin
      old_raw         <= win_mem[wr_pos];
      win_mem[wr_pos] <= samples.sample;
    end
  end

  // stage 1 item register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sample  <= samples.sample;
      s1_first   <= samples.first_of_sweep;
      s1_last    <= samples.last_of_sweep;
      s1_old_vld <= !samples.first_of_sweep && win_vld[wr_pos];
    end
  end

  // running window sum and saturated mean
  always_comb begin
    old_val   = s1_old_vld ? old_raw : '0;
    wsum_base = s1_first ? '0 : win_sum;
    wsum_next = wsum_base - WSUM_W'(old_val) + WSUM_W'(s1_sample);
    mean_full = wsum_next >> shift;
    if (mean_full > WSUM_W'({SAMPLE_BITS{1'b1}})) begin
      mean = '1;
    end else begin
      mean = mean_full[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum  <= '0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        win_sum <= wsum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_mean  <= mean;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
  end

  // peak, peak position and above-threshold count
  always_comb begin
    pk_base  = s2_first ? '0 : peak;
    pp_base  = s2_first ? '0 : peak_pos;
    sp_base  = s2_first ? '0 : sweep_pos;
    cnt_base = s2_first ? '0 : above;
    if (s2_mean > pk_base) begin
      pk_new = s2_mean;
      pp_new = sp_base;
    end else begin
      pk_new = pk_base;
      pp_new = pp_base;
    end
    sp_new  = (sp_base == '1) ? sp_base : sp_base + 1'b1;
    cnt_new = (s2_mean > thr && cnt_base < CNT_W'(CNT_MAX)) ? cnt_base + 1'b1 : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      peak_pos  <= '0;
      sweep_pos <= '0;
      above     <= '0;
      thr       <= THR_INIT;
    end else if (en && s2_valid) begin
      peak      <= pk_new;
      peak_pos  <= pp_new;
      sweep_pos <= sp_new;
      above     <= cnt_new;
      if (s2_last) begin
        thr <= pk_new >> 1;
      end
    end
  end

  // sweep record out
  assign q_push      = en && s2_valid && s2_last;
  assign q_rec.peak  = pk_new;
  assign q_rec.pos   = pp_new;
  assign q_rec.count = cnt_new;

endmodule

>>> rtl/core/spwa_queue.sv
// ----------------------------------------------------------------------------
// spwa_queue
// Short record queue between the sample front and the ring back end.
// ----------------------------------------------------------------------------
module spwa_queue import spwa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sweep_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output sweep_rec_t pop_rec,
  output logic       not_empty
);

  sweep_rec_t        slots [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_CW-1:0]   fill;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign pop_rec   = slots[rd_ptr];
  assign full      = (fill == Q_CW'(Q_DEPTH));
  assign not_empty = (fill != '0);

endmodule

>>> rtl/core/spwa_back.sv
// ----------------------------------------------------------------------------
// spwa_back
// Period ring: stores sweep records, keeps running sums, drives results.
// Sums are rebuilt by a read pass after each period count write.
// ----------------------------------------------------------------------------
module spwa_back import spwa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [PER_W-1:0] period_count,
  input  logic             recalc_start,
  input  logic             q_valid,
  input  sweep_rec_t       q_rec,
  output back_stat_t       stat,
  spwa_out_if.source       results
);

  logic [NCNT_W-1:0]  n_eff;
  logic               bk_en, busy, pop, rd_en;
  logic [RING_AW-1:0] ring_pos, rd_addr, rc_idx;
  sweep_rec_t         ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  sweep_rec_t         rd_rec, old_rec, new_rec, acc_rec, b1_rec, o_rec;
  logic               rd_vld, b1_valid, b1_inrange, o_valid;
  logic               rc_run, rc_acc;
  logic [PK_SUM_W-1:0] pk_sum, pk_sum_next, o_pk_sum;
  logic [WD_SUM_W-1:0] wd_sum, wd_sum_next, o_wd_sum;
  logic [IX_SUM_W-1:0] ix_sum, ix_sum_next, o_ix_sum;

  // effective number of periods
  always_comb begin
    if (period_count == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(period_count) > RING_DEPTH) begin
      n_eff = NCNT_W'(RING_DEPTH);
    end else begin
      n_eff = NCNT_W'(period_count);
    end
  end

  // handshake and pop
  assign bk_en       = !o_valid || results.ready;
  assign busy        = rc_run || rc_acc;
  assign pop         = q_valid && bk_en && !busy;
  assign stat.pop    = pop;
  assign stat.recalc = busy;
  assign rd_en       = pop || rc_run;
  assign rd_addr     = rc_run ? rc_idx : ring_pos;

  // ring memory, read-first at the slot being replaced
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec <= ring_mem[rd_addr];
      rd_vld <= ring_vld[rd_addr];
      if (pop) begin
        ring_mem[ring_pos] <= q_rec;
      end
    end
  end

  // slot valid bits and ring position
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      ring_pos <= '0;
    end else if (pop) begin
      ring_vld[ring_pos] <= 1'b1;
      ring_pos <= (ring_pos == '0) ? RING_AW'(n_eff - 1'b1) : ring_pos - 1'b1;
    end
  end

  // stage 1 item register
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (bk_en) begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_rec     <= q_rec;
      b1_inrange <= NCNT_W'(ring_pos) < n_eff;
    end
  end

  // incremental sum update
  always_comb begin
    old_rec     = (b1_inrange && rd_vld) ? rd_rec : '0;
    new_rec     = b1_inrange ? b1_rec : '0;
    acc_rec     = rd_vld ? rd_rec : '0;
    pk_sum_next = pk_sum - PK_SUM_W'(old_rec.peak) + PK_SUM_W'(new_rec.peak);
    wd_sum_next = wd_sum - WD_SUM_W'(old_rec.count) + WD_SUM_W'(new_rec.count);
    ix_sum_next = ix_sum - IX_SUM_W'(old_rec.pos) + IX_SUM_W'(new_rec.pos);
  end

  // rebuild pass over the summed slots
  always_ff @(posedge clk) begin
    if (rst) begin
      rc_run <= 1'b0;
      rc_acc <= 1'b0;
      rc_idx <= '0;
    end else begin
      rc_acc <= rc_run;
      if (recalc_start) begin
        rc_run <= 1'b1;
        rc_idx <= '0;
      end else if (rc_run) begin
        if (NCNT_W'(rc_idx) == n_eff - 1'b1) begin
          rc_run <= 1'b0;
        end else begin
          rc_idx <= rc_idx + 1'b1;
        end
      end
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      pk_sum <= '0;
      wd_sum <= '0;
      ix_sum <= '0;
    end else begin
      priority if (recalc_start) begin
        pk_sum <= '0;
        wd_sum <= '0;
        ix_sum <= '0;
      end else if (rc_acc) begin
        pk_sum <= pk_sum + PK_SUM_W'(acc_rec.peak);
        wd_sum <= wd_sum + WD_SUM_W'(acc_rec.count);
        ix_sum <= ix_sum + IX_SUM_W'(acc_rec.pos);
      end else if (bk_en && b1_valid) begin
        pk_sum <= pk_sum_next;
        wd_sum <= wd_sum_next;
        ix_sum <= ix_sum_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (bk_en) begin
      o_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_en && b1_valid) begin
      o_rec    <= b1_rec;
      o_pk_sum <= pk_sum_next;
      o_wd_sum <= wd_sum_next;
      o_ix_sum <= ix_sum_next;
    end
  end

  assign results.valid       = o_valid;
  assign results.peak_value  = o_rec.peak;
  assign results.peak_index  = o_rec.pos;
  assign results.width_count = o_rec.count;
  assign results.peak_sum    = o_pk_sum;
  assign results.width_sum   = o_wd_sum;
  assign results.index_sum   = o_ix_sum;

endmodule

>>> rtl/core/sweep_peak_width_averager.sv
// ----------------------------------------------------------------------------
// sweep_peak_width_averager
// Boxcar-smoothed ramp sweep peak/width detector with period averaging ring.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   sample, first_of_sweep, last_of_sweep
//   results   out  valid/ready   peak_value, peak_index, width_count, 3 sums
//   cfg       in   valid/ready   index, data (ready always high)
//
// One sample item per cycle while the queue has room. After its last sample is
// accepted, a result passes the window read and peak stages, a queue slot, the
// ring read and the output register. A period_count write starts a rebuild pass
// over the slots of the effective period count, during which the ring takes no
// record; the 4-entry queue absorbs sweep ends and the intake stalls only once the queue is full.
// Synchronous reset; window and ring slots are marked empty at once.
// ----------------------------------------------------------------------------
module sweep_peak_width_averager import spwa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spwa_in_if.sink     samples,
  spwa_out_if.source  results,
  spwa_cfg_if.sink    cfg
);

  logic [EXP_W-1:0] window_exponent, shift;
  logic [PER_W-1:0] period_count;
  logic             cfg_fire, recalc_start;
  logic             q_push, q_full, q_valid;
  sweep_rec_t       q_in_rec, q_out_rec;
  back_stat_t       bk_stat;

  // configuration registers
  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid && cfg.ready;
  assign recalc_start = cfg_fire && (cfg.index == REG_PERIOD_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_exponent <= '0;
      period_count    <= PER_RESET;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_WINDOW_EXP:   window_exponent <= cfg.data[EXP_W-1:0];
        REG_PERIOD_COUNT: period_count    <= cfg.data[PER_W-1:0];
        default:          ;
      endcase
    end
  end

  // effective window shift
  assign shift = (int'(window_exponent) >= EXP_MIN && int'(window_exponent) <= EXP_MAX) ?
                 window_exponent : '0;

  spwa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_rec   (q_in_rec)
  );

  spwa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (q_in_rec),
    .full      (q_full),
    .pop       (bk_stat.pop),
    .pop_rec   (q_out_rec),
    .not_empty (q_valid)
  );

  spwa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .period_count (period_count),
    .recalc_start (recalc_start),
    .q_valid      (q_valid),
    .q_rec        (q_out_rec),
    .stat         (bk_stat),
    .results      (results)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("sweep record pushed into a full queue");

  // ring takes no record during a rebuild pass
  a_no_pop_in_recalc: assert property (@(posedge clk) disable iff (rst)
    bk_stat.recalc |-> !bk_stat.pop)
    else $error("record popped during ring sum rebuild");

  // a period count write starts a rebuild
  a_recalc_starts: assert property (@(posedge clk) disable iff (rst)
    (cfg_fire && cfg.index == REG_PERIOD_COUNT) |=> bk_stat.recalc)
    else $error("period count write did not start a rebuild");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sweep peak/width averager.
// Runs directed sweeps (sweep markers, threshold edges, window lengths, window
// resized mid-sweep, period counts, a long sweep at full rate) and then random
// ramp sweeps with random gaps on both channels. Every accepted sample goes
// through a local predictor; each sweep result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench import spwa_pkg::*; ();

  localparam int TIMEOUT_NS    = 2_000_000;
  localparam int IDLE_CYCLES   = 140;  // result latency plus a full ring rebuild
  localparam int TAIL_CYCLES   = 20;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 10;
  localparam int MAX_GAP       = 13;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 140;
  localparam int LONG_SWEEP    = 300;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
  localparam int POS_MAX       = (1 << POS_W) - 1;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [SAMPLE_BITS-1:0] peak;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [PK_SUM_W-1:0]    peak_sum;
    logic [WD_SUM_W-1:0]    width_sum;
    logic [IX_SUM_W-1:0]    index_sum;
  } sweep_result_t;

  logic clk;
  logic rst;

  spwa_in_if  samples_ch ();
  spwa_out_if results_ch ();
  spwa_cfg_if cfg_ch ();

  sweep_peak_width_averager uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  // predictor state
  logic [EXP_W-1:0]       win_exp_cfg;
  logic [PER_W-1:0]       period_cfg;
  logic [SAMPLE_BITS-1:0] win_store [WIN_DEPTH];
  logic [WSUM_W-1:0]      win_sum;
  logic [WIN_AW-1:0]      win_pos;
  logic [POS_W-1:0]       sweep_pos;
  logic [POS_W-1:0]       peak_pos;
  logic [SAMPLE_BITS-1:0] peak_val;
  logic [SAMPLE_BITS-1:0] width_thr;
  logic [CNT_W-1:0]       above_cnt;
  logic [SAMPLE_BITS-1:0] peak_ring [RING_DEPTH];
  logic [CNT_W-1:0]       width_ring [RING_DEPTH];
  logic [POS_W-1:0]       index_ring [RING_DEPTH];
  logic [RING_AW-1:0]     ring_pos;

  sweep_result_t due_sweeps[$];
  bit src_gaps;
  bit snk_gaps;
  int stall_left;
  int fault_count;
  int samples_sent;
  int sweeps_checked;
  int reg_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic reset_model();
    win_exp_cfg = '0;
    period_cfg  = PER_RESET;
    foreach (win_store[i]) win_store[i] = '0;
    win_sum   = '0;
    win_pos   = '0;
    sweep_pos = '0;
    peak_pos  = '0;
    peak_val  = '0;
    above_cnt = '0;
    width_thr = THR_INIT;
    foreach (peak_ring[i]) begin
      peak_ring[i]  = '0;
      width_ring[i] = '0;
      index_ring[i] = '0;
    end
    ring_pos = '0;
  endtask

  // smoothing, peak and width tracking for one sample; queues a result at sweep end
  task automatic smooth_and_track(input logic [SAMPLE_BITS-1:0] s, input bit first,
                                  input bit last);
    sweep_result_t r;
    logic [EXP_W-1:0] shift;
    logic [WSUM_W-1:0] scaled;
    logic [SAMPLE_BITS-1:0] mean;
    int n;
    int psum;
    int wsum;
    int isum;
    shift = (win_exp_cfg >= EXP_MIN && win_exp_cfg <= EXP_MAX) ? win_exp_cfg : '0;
    if (first) begin
      foreach (win_store[i]) win_store[i] = '0;
      win_sum   = '0;
      win_pos   = '0;
      sweep_pos = '0;
      peak_val  = '0;
      peak_pos  = '0;
      above_cnt = '0;
    end
    // boxcar update, position counts down and wraps to window length - 1
    win_sum = win_sum - win_store[win_pos] + s;
    win_store[win_pos] = s;
    win_pos = (win_pos == 0) ? WIN_AW'((1 << shift) - 1) : win_pos - 1'b1;
    scaled = win_sum >> shift;
    mean = (scaled > SMAX) ? SMAX : scaled[SAMPLE_BITS-1:0];
    // first occurrence of the peak
    if (mean > peak_val) begin
      peak_val = mean;
      peak_pos = sweep_pos;
    end
    if (sweep_pos < POS_MAX) sweep_pos = sweep_pos + 1'b1;
    if (mean > width_thr && above_cnt < CNT_MAX) above_cnt = above_cnt + 1'b1;
    if (!last) return;
    // sweep end: store in ring, new threshold, sum the active slots
    n = (period_cfg == 0) ? 1 : ((period_cfg > RING_DEPTH) ? RING_DEPTH : period_cfg);
    peak_ring[ring_pos]  = peak_val;
    width_ring[ring_pos] = above_cnt;
    index_ring[ring_pos] = peak_pos;
    width_thr = peak_val >> 1;
    ring_pos = (ring_pos == 0) ? RING_AW'(n - 1) : ring_pos - 1'b1;
    psum = 0;
    wsum = 0;
    isum = 0;
    for (int i = 0; i < n; i++) begin
      psum += peak_ring[i];
      wsum += width_ring[i];
      isum += index_ring[i];
    end
    r.peak      = peak_val;
    r.pos       = peak_pos;
    r.count     = above_cnt;
    r.peak_sum  = PK_SUM_W'(psum);
    r.width_sum = WD_SUM_W'(wsum);
    r.index_sum = IX_SUM_W'(isum);
    due_sweeps.push_back(r);
  endtask

  task automatic note_fault(input string what, input int exp_v, input int act_v);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, act_v);
  endtask

  // result side: random stalls, compare against the oldest expected sweep
  initial begin : result_sink
    sweep_result_t r;
    results_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        if (due_sweeps.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t unexpected result, peak_value %0d", $time, results_ch.peak_value);
        end else begin
          r = due_sweeps.pop_front();
          if (r.peak !== results_ch.peak_value)
            note_fault("peak_value", r.peak, results_ch.peak_value);
          if (r.pos !== results_ch.peak_index)
            note_fault("peak_index", r.pos, results_ch.peak_index);
          if (r.count !== results_ch.width_count)
            note_fault("width_count", r.count, results_ch.width_count);
          if (r.peak_sum !== results_ch.peak_sum)
            note_fault("peak_sum", r.peak_sum, results_ch.peak_sum);
          if (r.width_sum !== results_ch.width_sum)
            note_fault("width_sum", r.width_sum, results_ch.width_sum);
          if (r.index_sum !== results_ch.index_sum)
            note_fault("index_sum", r.index_sum, results_ch.index_sum);
          sweeps_checked++;
        end
        stall_left = snk_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      @(negedge clk);
      if (stall_left != 0 && results_ch.valid === 1'b1) stall_left--;
      results_ch.ready <= (stall_left == 0);
    end
  end

  // one sample item; called and returns at a falling edge
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit first,
                             input bit last);
    int gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.valid          <= 1'b1;
    samples_ch.sample         <= s;
    samples_ch.first_of_sweep <= first;
    samples_ch.last_of_sweep  <= last;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    smooth_and_track(s, first, last);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_WINDOW_EXP:   win_exp_cfg = data[EXP_W-1:0];
      REG_PERIOD_COUNT: period_cfg  = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // block idle: nothing expected and the pipeline and ring rebuild drained
  task automatic wait_idle();
    samples_ch.valid <= 1'b0;
    while (due_sweeps.size() != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  // sweep markers, field extremes and the strict threshold compare
  task automatic test_markers_and_threshold();
    // initial threshold: 511 does not count, 512 does; repeated peak keeps its index
    send_sample(10'd0, 1'b1, 1'b0);
    send_sample(10'd511, 1'b0, 1'b0);
    send_sample(10'd512, 1'b0, 1'b0);
    send_sample(SMAX, 1'b0, 1'b0);
    send_sample(10'h155, 1'b0, 1'b0);
    send_sample(10'h2aa, 1'b0, 1'b0);
    send_sample(SMAX, 1'b0, 1'b0);
    send_sample(10'd0, 1'b0, 1'b1);
    // single sample sweep sets threshold to 300
    send_sample(10'd600, 1'b1, 1'b1);
    send_sample(10'd300, 1'b1, 1'b0);
    send_sample(10'd301, 1'b0, 1'b0);
    send_sample(10'd299, 1'b0, 1'b1);
    // sweeps without a start marker keep accumulating
    send_sample(10'd5, 1'b0, 1'b0);
    send_sample(10'd1000, 1'b0, 1'b1);
    send_sample(10'd7, 1'b0, 1'b1);
  endtask

  // longest window, out-of-range exponent, exponent with upper data bits set
  task automatic test_window_lengths();
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd6);
    send_sample(SMAX, 1'b1, 1'b0);
    repeat (4) send_sample(SMAX, 1'b0, 1'b0);
    send_sample(10'd64, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'hff);
    send_sample(10'd200, 1'b1, 1'b0);
    send_sample(10'd900, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'h09);
    send_sample(10'd3, 1'b1, 1'b0);
    send_sample(10'd1, 1'b0, 1'b0);
    send_sample(SMAX, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd4);
    send_sample(10'd800, 1'b1, 1'b0);
    send_sample(10'd400, 1'b0, 1'b1);
  endtask

  // window shrinks and grows while a sweep is open
  task automatic test_window_resize_mid_sweep();
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd6);
    send_sample(10'd800, 1'b1, 1'b0);
    repeat (7) send_sample(10'd800, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd2);
    repeat (5) send_sample(10'd100, 1'b0, 1'b0);
    send_sample(SMAX, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd1);
    send_sample(10'd900, 1'b1, 1'b0);
    repeat (3) send_sample(10'd950, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd5);
    repeat (4) send_sample(10'd20, 1'b0, 1'b0);
    send_sample(10'd1010, 1'b0, 1'b1);
  endtask

  // period count of zero, one, above the ring depth; sweeps close during the rebuild
  task automatic test_period_counts();
    logic [PER_W-1:0] counts [7];
    counts = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd129, 8'd3, 8'd128};
    foreach (counts[k]) begin
      wait_idle();
      write_reg(REG_PERIOD_COUNT, counts[k]);
      if (k == 2) begin
        write_reg(REG_SPARE_2, 8'hff);
        write_reg(REG_SPARE_3, 8'h00);
      end
      repeat (3) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)), 1'b1, 1'b1);
    end
  endtask

  // long sweep with no gaps on either channel and a window of one
  task automatic test_long_sweep();
    bit keep_src;
    bit keep_snk;
    keep_src = src_gaps;
    keep_snk = snk_gaps;
    wait_idle();
    write_reg(REG_WINDOW_EXP, 8'd0);
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    send_sample(10'd1000, 1'b1, 1'b0);
    repeat (LONG_SWEEP - 1) send_sample(10'd1000, 1'b0, 1'b0);
    send_sample(SMAX, 1'b0, 1'b1);
    src_gaps = keep_src;
    snk_gaps = keep_snk;
  endtask

  // random settings per phase, mostly well-formed ramp sweeps plus loose items
  task automatic test_random_sweeps();
    int phase_items;
    int len;
    int shape;
    int top;
    int apex;
    int step;
    int v;
    int loose_n;
    bit has_first;
    bit has_last;
    logic [PER_W-1:0] per;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_WINDOW_EXP, CFG_DATA_W'($urandom_range(0, 255)));
      case ($urandom_range(0, 7))
        0:       per = 8'd0;
        1:       per = 8'd1;
        2:       per = 8'd2;
        3:       per = 8'd128;
        4:       per = 8'd255;
        5:       per = 8'd129;
        default: per = PER_W'($urandom_range(1, RING_DEPTH));
      endcase
      write_reg(REG_PERIOD_COUNT, per);
      src_gaps = ($urandom_range(0, 3) != 0);
      snk_gaps = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) begin
          src_gaps = ($urandom_range(0, 2) != 0);
          snk_gaps = ($urandom_range(0, 2) != 0);
        end
        if ($urandom_range(0, 6) == 0) begin
          // loose items with random markers
          loose_n = $urandom_range(1, 5);
          repeat (loose_n)
            send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
          phase_items += loose_n;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
          has_first = ($urandom_range(0, 9) != 0);
          has_last  = ($urandom_range(0, 19) != 0);
          shape = $urandom_range(0, 3);
          top   = $urandom_range(0, SAMPLE_TOP);
          apex  = $urandom_range(0, len - 1);
          step  = $urandom_range(1, 64);
          for (int i = 0; i < len; i++) begin
            case (shape)
              0: v = $urandom_range(0, SAMPLE_TOP);
              1: v = top - step * ((i > apex) ? i - apex : apex - i) + $urandom_range(0, 7);
              2: v = top;
              default: v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
            endcase
            if (v < 0) v = 0;
            if (v > SAMPLE_TOP) v = SAMPLE_TOP;
            send_sample(SAMPLE_BITS'(v), has_first && i == 0, has_last && i == len - 1);
          end
          phase_items += len;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    int drained;
    rst = 1'b1;
    samples_ch.valid          = 1'b0;
    samples_ch.sample         = '0;
    samples_ch.first_of_sweep = 1'b0;
    samples_ch.last_of_sweep  = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WINDOW_EXP;
    cfg_ch.data  = '0;
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_markers_and_threshold();
    test_window_lengths();
    test_window_resize_mid_sweep();
    test_period_counts();
    test_long_sweep();
    test_random_sweeps();

    // drain outstanding results
    samples_ch.valid <= 1'b0;
    drained = 0;
    while (due_sweeps.size() != 0 && drained < DRAIN_LIMIT) begin
      @(negedge clk);
      drained++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_sweeps.size() != 0) begin
      $display("%0d sweep results never arrived", due_sweeps.size());
      fault_count += due_sweeps.size();
    end
    $display("summary: %0d samples sent, %0d sweep results checked, %0d register writes",
             samples_sent, sweeps_checked, reg_writes);
    $display("summary: %0d faults found", fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
